FILE: rtl/iqd_pkg.sv
package iqd_pkg;

    localparam int SMP_W   = 12;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = SMP_W + 1 + COEF_W;
    localparam int SUM_W   = 48;
    localparam int OUT_W   = 29;
    localparam int CNT_W   = 21;
    localparam int SKIP_W  = 16;
    localparam int DVS_W   = CNT_W - 1;
    localparam int NUM_CH  = 3;
    localparam int NUM_SUM = 2 * NUM_CH;
    localparam int SEL_W   = $clog2(NUM_SUM);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = CNT_W;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 200;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_SAMPLES = 1'd1;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [CNT_W-1:0]  SAMPLE_COUNT_RST = 21'd1024;
    localparam logic [SKIP_W-1:0] IGNORE_RST       = 16'd128;
    localparam logic [CNT_W-1:0]  TAKEN_MAX        = {CNT_W{1'b1}};

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    localparam int    CORDIC_STEPS = 20;
    localparam longint CORDIC_X0   = 64'sd652032874;
    localparam longint ATAN_STEPS [CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304
    };

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [OUT_W-1:0]  t_avg;

    typedef struct packed {
        logic clear;
        logic load;
        logic acc;
    } t_lane_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT
    } t_state;

    // Rounds a Q2.30 value to Q1.15 and clamps it to the coefficient range.
    function automatic t_coef iqd_to_q15(input longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 64'sd32767) begin
            r = 64'sd32767;
        end else if (r < -64'sd32768) begin
            r = -64'sd32768;
        end
        return t_coef'(r);
    endfunction

    // Cosine in the upper half, sine in the lower half, for an angle given
    // in units of 2^32 per turn. Used only to build the coefficient table.
    function automatic logic [2*COEF_W-1:0] iqd_rom_entry(input logic [31:0] ang);
        longint x;
        longint y;
        longint z;
        longint nx;
        t_coef  c;
        t_coef  s;
        t_coef  rc;
        t_coef  rs;
        x = CORDIC_X0;
        y = 0;
        z = longint'(ang[29:0]);
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            if (z >= 0) begin
                nx = x - (y >>> k);
                y  = y + (x >>> k);
                z  = z - ATAN_STEPS[k];
            end else begin
                nx = x + (y >>> k);
                y  = y - (x >>> k);
                z  = z + ATAN_STEPS[k];
            end
            x = nx;
        end
        c = iqd_to_q15(x);
        s = iqd_to_q15(y);
        unique case (ang[31:30])
            2'd0: begin rc = c;  rs = s;  end
            2'd1: begin rc = -s; rs = c;  end
            2'd2: begin rc = -c; rs = -s; end
            2'd3: begin rc = s;  rs = -c; end
        endcase
        return {rc, rs};
    endfunction

endpackage

FILE: rtl/iqd_lane.sv
module iqd_lane (
    input  logic                       i_clk,
    input  iqd_pkg::t_lane_ctl         i_ctl,
    input  logic [iqd_pkg::SMP_W-1:0]  i_sample,
    input  iqd_pkg::t_coef             i_cos,
    input  iqd_pkg::t_coef             i_sin,
    output iqd_pkg::t_sum              o_sum_i,
    output iqd_pkg::t_sum              o_sum_q
);
    import iqd_pkg::*;

    logic [SMP_W-1:0]         r_smp;
    logic signed [PROD_W-1:0] r_prod_i;
    logic signed [PROD_W-1:0] r_prod_q;
    t_sum                     r_sum_i;
    t_sum                     r_sum_q;
    t_sum                     n_sum_i;
    t_sum                     n_sum_q;

    function automatic t_sum sat_add(input t_sum a, input logic signed [PROD_W-1:0] p);
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {{(SUM_W+1-PROD_W){p[PROD_W-1]}}, p};
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return s[SUM_W-1:0];
    endfunction

    always_comb begin
        n_sum_i = sat_add(r_sum_i, r_prod_i);
        n_sum_q = sat_add(r_sum_q, r_prod_q);
    end

    // The products run freely; the controller spaces load and accumulate
    // so that the product of the loaded sample is ready in between.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_smp <= i_sample;
        end
        r_prod_i <= $signed({1'b0, r_smp}) * i_cos;
        r_prod_q <= $signed({1'b0, r_smp}) * i_sin;
        if (i_ctl.clear) begin
            r_sum_i <= '0;
            r_sum_q <= '0;
        end else if (i_ctl.acc) begin
            r_sum_i <= n_sum_i;
            r_sum_q <= n_sum_q;
        end
    end

    assign o_sum_i = r_sum_i;
    assign o_sum_q = r_sum_q;

endmodule

FILE: rtl/iqd_div.sv
module iqd_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  iqd_pkg::t_sum             i_dividend,
    input  logic [iqd_pkg::DVS_W-1:0] i_divisor,
    output logic                      o_done,
    output iqd_pkg::t_avg             o_quot
);
    import iqd_pkg::*;

    localparam int ITER_W = $clog2(SUM_W);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(SUM_W - 1);
    localparam logic [SUM_W-1:0]  POS_LIM = SUM_W'(OUT_MAX);
    localparam logic [SUM_W-1:0]  NEG_LIM = POS_LIM + SUM_W'(1);

    logic              r_busy;
    logic              r_done;
    logic [ITER_W-1:0] r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_dvs;
    logic              r_neg;
    logic [DVS_W:0]    w_rem_sh;
    logic [DVS_W:0]    w_diff;
    logic              w_bit;

    // Restoring division of the magnitude, one quotient bit per cycle.
    always_comb begin
        w_rem_sh = {r_rem, r_quo[SUM_W-1]};
        w_diff   = w_rem_sh - {1'b0, r_dvs};
        w_bit    = (w_rem_sh >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == ITER_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + ITER_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : i_dividend;
            r_neg <= i_dividend[SUM_W-1];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_bit ? w_diff[DVS_W-1:0] : w_rem_sh[DVS_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], w_bit};
        end
    end

    // Truncation toward zero falls out of dividing the magnitude.
    always_comb begin
        if (!r_neg) begin
            o_quot = (r_quo > POS_LIM) ? OUT_MAX : r_quo[OUT_W-1:0];
        end else begin
            o_quot = (r_quo > NEG_LIM) ? OUT_MIN : OUT_W'(-r_quo[OUT_W-1:0]);
        end
    end

    assign o_done = r_done;

endmodule

FILE: rtl/three_channel_iq_demodulator_top.sv
// Three-channel I/Q demodulator at a single DFT bin.
// Input transactions on s_axis: tuser selects a start (0) or a sample triple
// (1); tdata carries the reference, port one and port two samples. A start
// clears the sums and the sample count and loads the settling counter from
// ignore_samples; sample triples then are dropped until that counter is used
// up, and the rest are mixed with the cosine and sine table and summed.
// A start or a dropped triple needs only the accept step; an accumulated triple
// passes through accept, multiply and accumulate in the three channel lanes.
// At a table boundary where the count reaches sample_count, the six sums are
// divided by count/2 in one shared serial divider, one quotient after another,
// and the results are held for the output register. No input is taken meanwhile.
// The result sits in an output register on m_axis; while the receiver
// stalls, the block keeps taking input and works on the next measurement,
// and only the final load of a new result waits for the register to empty.
// Configuration writes are taken at any time and are meant for idle periods.
// After reset the block is idle, sample_count is 1024, ignore_samples is
// 128, and sample triples are ignored until a start arrives.
module three_channel_iq_demodulator_top #(
    parameter int TABLE_LEN    = 8,
    parameter int TABLE_CYCLES = 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [iqd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [iqd_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // ref_sample, port1_sample, port2_sample, zero padding
    input  logic [iqd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // opcode
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // ref_i, ref_q, port1_i, port1_q, port2_i, port2_q, samples_used, zero padding
    output logic [iqd_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import iqd_pkg::*;

    localparam int PH_W = $clog2(TABLE_LEN);
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(TABLE_LEN - 1);
    localparam logic [CNT_W:0]  STEP    = (CNT_W + 1)'(TABLE_LEN);
    localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(NUM_SUM - 1);

    t_coef w_rom_cos [TABLE_LEN];
    t_coef w_rom_sin [TABLE_LEN];

    for (genvar g = 0; g < TABLE_LEN; g++) begin : g_rom
        localparam longint unsigned P = (longint'(TABLE_CYCLES) * g) % TABLE_LEN;
        localparam logic [31:0] ANG = 32'((P << 32) / TABLE_LEN);
        localparam logic [2*COEF_W-1:0] CS = iqd_rom_entry(ANG);
        assign w_rom_cos[g] = CS[2*COEF_W-1:COEF_W];
        assign w_rom_sin[g] = CS[COEF_W-1:0];
    end

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_sample_count;
    logic [SKIP_W-1:0] r_ignore;
    logic             r_running;
    logic [SKIP_W-1:0] r_skip;
    logic [PH_W-1:0]  r_phase;
    logic [CNT_W-1:0] r_taken;
    t_coef            r_cos;
    t_coef            r_sin;
    logic [SEL_W-1:0] r_sel;
    logic [DVS_W-1:0] r_divisor;
    logic [CNT_W-1:0] r_used;
    t_avg             r_quot [NUM_SUM];
    logic             r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    logic             w_accept;
    logic             w_start;
    logic             w_take;
    logic             w_last_phase;
    logic [CNT_W:0]   w_next_raw;
    logic [CNT_W-1:0] w_next;
    logic             w_finish;
    logic             w_div_start;
    logic             w_out_load;
    logic             w_out_free;
    t_lane_ctl        w_lane_ctl;
    t_sum             w_sums [NUM_SUM];
    logic             w_div_done;
    t_avg             w_div_quot;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;

    always_comb begin
        w_next_raw   = {1'b0, r_taken} + STEP;
        w_next       = w_next_raw[CNT_W] ? TAKEN_MAX : w_next_raw[CNT_W-1:0];
        w_last_phase = (r_phase == PH_LAST);
        w_finish     = w_last_phase &&
                       ((w_next >= r_sample_count) || (w_next == TAKEN_MAX));
    end

    // Control outputs of the sequencer.
    always_comb begin
        s_axis_tready    = 1'b0;
        w_start          = 1'b0;
        w_take           = 1'b0;
        w_div_start      = 1'b0;
        w_out_load       = 1'b0;
        w_lane_ctl       = '0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                w_start = w_accept && (s_axis_tuser == OP_START);
                w_take  = w_accept && (s_axis_tuser == OP_SAMPLE) && r_running &&
                          (r_skip == '0);
                w_lane_ctl.clear = w_start;
                w_lane_ctl.load  = w_take;
            end
            ST_MUL: begin
            end
            ST_ACC: begin
                w_lane_ctl.acc = 1'b1;
            end
            ST_DIV_START: begin
                w_div_start = 1'b1;
            end
            ST_DIV_WAIT: begin
            end
            ST_EMIT: begin
                w_out_load = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (w_take) n_state = ST_MUL;
            ST_MUL:       n_state = ST_ACC;
            ST_ACC:       n_state = w_finish ? ST_DIV_START : ST_IDLE;
            ST_DIV_START: n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = (r_sel == SEL_LAST) ? ST_EMIT : ST_DIV_START;
                end
            end
            ST_EMIT:      if (w_out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_sample_count <= SAMPLE_COUNT_RST;
            r_ignore       <= IGNORE_RST;
            r_running      <= 1'b0;
            r_skip         <= '0;
            r_phase        <= '0;
            r_taken        <= '0;
            r_sel          <= '0;
            r_m_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_SAMPLE_COUNT:   r_sample_count <= i_cfg_data;
                    REG_IGNORE_SAMPLES: r_ignore       <= i_cfg_data[SKIP_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_start) begin
                r_running <= 1'b1;
                r_skip    <= r_ignore;
                r_phase   <= '0;
                r_taken   <= '0;
            end else if (r_state == ST_IDLE && w_accept && r_running &&
                         r_skip != '0) begin
                r_skip <= r_skip - SKIP_W'(1);
            end
            if (r_state == ST_ACC) begin
                if (w_last_phase) begin
                    r_phase <= '0;
                    r_taken <= w_next;
                    if (w_finish) begin
                        r_running <= 1'b0;
                    end
                end else begin
                    r_phase <= r_phase + PH_W'(1);
                end
            end
            if (r_state == ST_DIV_WAIT && w_div_done) begin
                r_sel <= (r_sel == SEL_LAST) ? '0 : r_sel + SEL_W'(1);
            end
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cos <= w_rom_cos[r_phase];
            r_sin <= w_rom_sin[r_phase];
        end
        // The count is at least the table length here, so count/2 is never zero.
        if (r_state == ST_ACC && w_finish) begin
            r_divisor <= w_next[CNT_W-1:1];
            r_used    <= w_next;
        end
        if (r_state == ST_DIV_WAIT && w_div_done) begin
            r_quot[r_sel] <= w_div_quot;
        end
        if (w_out_load) begin
            r_m_data <= {5'd0, r_used, r_quot[5], r_quot[4], r_quot[3],
                         r_quot[2], r_quot[1], r_quot[0]};
        end
    end

    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
        iqd_lane u_lane (
            .i_clk    (i_clk),
            .i_ctl    (w_lane_ctl),
            .i_sample (s_axis_tdata[ch*SMP_W +: SMP_W]),
            .i_cos    (r_cos),
            .i_sin    (r_sin),
            .o_sum_i  (w_sums[2*ch]),
            .o_sum_q  (w_sums[2*ch+1])
        );
    end

    iqd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_sums[r_sel]),
        .i_divisor  (r_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

FILE: tb/three_channel_iq_demodulator_top_tb.sv
`timescale 1ns / 100ps

module three_channel_iq_demodulator_top_tb;

    import iqd_pkg::*;

    localparam int TABLE_LEN    = 8;
    localparam int TABLE_CYCLES = 1;
    localparam int SETTLE_CYCLES = 400;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int UNSIGNED_CNT_MAX = (1 << CNT_W) - 1;

    typedef struct packed {
        logic             op;
        logic [SMP_W-1:0] p2;
        logic [SMP_W-1:0] p1;
        logic [SMP_W-1:0] rf;
    } t_triple;

    typedef struct {
        t_avg             avg [NUM_SUM];
        logic [CNT_W-1:0] used;
    } t_iq_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    three_channel_iq_demodulator_top #(
        .TABLE_LEN   (TABLE_LEN),
        .TABLE_CYCLES(TABLE_CYCLES)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Demodulator state as seen by the predictor.
    longint      cos_tab [TABLE_LEN];
    longint      sin_tab [TABLE_LEN];
    int unsigned cfg_sample_count = SAMPLE_COUNT_RST;
    int unsigned cfg_ignore = IGNORE_RST;
    bit          meas_running = 1'b0;
    int unsigned skip_left = 0;
    int unsigned table_phase = 0;
    int unsigned samples_taken = 0;
    longint      iq_sums [NUM_SUM];

    t_triple    triple_fifo [$];
    t_iq_result expected_avgs [$];
    int         err_count = 0;
    int         cycle_count = 0;

    string sum_names [NUM_SUM] = '{"ref_i", "ref_q", "port1_i", "port1_q",
                                   "port2_i", "port2_q"};

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("three_channel_iq_demodulator_top_tb NOT OK");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic longint q15_round(input longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 64'sd32767) begin
            r = 64'sd32767;
        end else if (r < -64'sd32768) begin
            r = -64'sd32768;
        end
        return r;
    endfunction

    // Coefficient table from a 20-step CORDIC rotation of the residual
    // within the quadrant, followed by the quadrant swap and negate.
    function automatic void build_coef_table();
        longint      p;
        logic [31:0] ang;
        longint      x;
        longint      y;
        longint      z;
        longint      nx;
        longint      c;
        longint      s;
        for (int i = 0; i < TABLE_LEN; i++) begin
            p   = longint'((TABLE_CYCLES * i) % TABLE_LEN);
            ang = 32'((p << 32) / TABLE_LEN);
            x   = 64'sd652032874;
            y   = 0;
            z   = longint'(ang[29:0]);
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                if (z >= 0) begin
                    nx = x - (y >>> k);
                    y  = y + (x >>> k);
                    z  = z - ATAN_STEPS[k];
                end else begin
                    nx = x + (y >>> k);
                    y  = y - (x >>> k);
                    z  = z + ATAN_STEPS[k];
                end
                x = nx;
            end
            c = q15_round(x);
            s = q15_round(y);
            case (ang[31:30])
                2'd0: begin cos_tab[i] = c;  sin_tab[i] = s;  end
                2'd1: begin cos_tab[i] = -s; sin_tab[i] = c;  end
                2'd2: begin cos_tab[i] = -c; sin_tab[i] = -s; end
                default: begin cos_tab[i] = s; sin_tab[i] = -c; end
            endcase
        end
    endfunction

    function automatic longint clamp_range(input longint v, input longint lo,
                                           input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void demod_step(input t_triple t);
        longint      smp [NUM_CH];
        int unsigned ph;
        int unsigned nxt;
        longint      div;
        t_iq_result  r;
        if (t.op == OP_START) begin
            foreach (iq_sums[j]) iq_sums[j] = 0;
            table_phase   = 0;
            samples_taken = 0;
            skip_left     = cfg_ignore;
            meas_running  = 1'b1;
            return;
        end
        if (!meas_running) begin
            return;
        end
        if (skip_left != 0) begin
            skip_left--;
            return;
        end
        smp[0] = longint'(t.rf);
        smp[1] = longint'(t.p1);
        smp[2] = longint'(t.p2);
        ph = (table_phase < TABLE_LEN) ? table_phase : 0;
        for (int j = 0; j < NUM_CH; j++) begin
            iq_sums[2*j]   = clamp_range(iq_sums[2*j] + smp[j] * cos_tab[ph],
                                         longint'(SUM_MIN), longint'(SUM_MAX));
            iq_sums[2*j+1] = clamp_range(iq_sums[2*j+1] + smp[j] * sin_tab[ph],
                                         longint'(SUM_MIN), longint'(SUM_MAX));
        end
        ph++;
        if (ph < TABLE_LEN) begin
            table_phase = ph;
            return;
        end
        table_phase = 0;
        nxt = samples_taken + TABLE_LEN;
        if (nxt > UNSIGNED_CNT_MAX) begin
            nxt = UNSIGNED_CNT_MAX;
        end
        samples_taken = nxt;
        if (samples_taken < cfg_sample_count && samples_taken < UNSIGNED_CNT_MAX) begin
            return;
        end
        div = longint'(samples_taken / 2);
        if (div < 1) begin
            div = 1;
        end
        for (int j = 0; j < NUM_SUM; j++) begin
            r.avg[j] = t_avg'(clamp_range(iq_sums[j] / div, longint'(OUT_MIN),
                                          longint'(OUT_MAX)));
        end
        r.used = CNT_W'(samples_taken);
        meas_running = 1'b0;
        expected_avgs.push_back(r);
    endfunction

    // Sender: bursts of random length separated by random gaps.
    t_triple drv_item;
    int      burst_left = 1;
    int      gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                demod_step(drv_item);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left      <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (triple_fifo.size() != 0) begin
                    drv_item      = triple_fifo.pop_front();
                    s_axis_tdata  <= IN_DATA_W'({drv_item.p2, drv_item.p1, drv_item.rf});
                    s_axis_tuser  <= drv_item.op;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: segments of always ready, random stalls, or a long stall.
    int rx_mode = 0;
    int rx_seg_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_seg_left == 0) begin
                rx_mode     <= $urandom_range(0, 3);
                rx_seg_left <= $urandom_range(20, 300);
            end else begin
                rx_seg_left <= rx_seg_left - 1;
            end
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 7) != 0);
                default: m_axis_tready <= 1'b0;
            endcase
        end
    end

    // Monitor: every result transaction is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_iq_result want;
        t_avg       got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_avgs.size() == 0) begin
                flag_error("result transaction with no expected result");
            end else begin
                want = expected_avgs.pop_front();
                for (int j = 0; j < NUM_SUM; j++) begin
                    got = m_axis_tdata[OUT_W*j +: OUT_W];
                    if (got !== want.avg[j]) begin
                        flag_error($sformatf("%s got %0d expected %0d", sum_names[j],
                                             got, want.avg[j]));
                    end
                end
                if (m_axis_tdata[OUT_W*NUM_SUM +: CNT_W] !== want.used) begin
                    flag_error($sformatf("samples_used got %0d expected %0d",
                                         m_axis_tdata[OUT_W*NUM_SUM +: CNT_W], want.used));
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(val);
        if (idx == REG_SAMPLE_COUNT) begin
            cfg_sample_count = val & UNSIGNED_CNT_MAX;
        end else begin
            cfg_ignore = val & 16'hFFFF;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every item is sent and every result is back, then lets the
    // divider run out before the caller touches the registers.
    task automatic wait_idle();
        while (triple_fifo.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_avgs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [SMP_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return SMP_W'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic void push_item(input logic op, input logic [SMP_W-1:0] rf,
                                      input logic [SMP_W-1:0] p1,
                                      input logic [SMP_W-1:0] p2);
        t_triple t;
        t.op = op;
        t.rf = rf;
        t.p1 = p1;
        t.p2 = p2;
        triple_fifo.push_back(t);
    endfunction

    function automatic void push_random_samples(input int n);
        for (int i = 0; i < n; i++) begin
            push_item(OP_SAMPLE, rand_sample(), rand_sample(), rand_sample());
        end
    endfunction

    // A start, the settling triples, then enough triples to finish the run.
    // Returns the number of summed triples plus one for the start.
    function automatic int push_measurement();
        int n;
        n = (cfg_sample_count == 0) ? TABLE_LEN
            : ((cfg_sample_count + TABLE_LEN - 1) / TABLE_LEN) * TABLE_LEN;
        push_item(OP_START, rand_sample(), rand_sample(), rand_sample());
        push_random_samples(cfg_ignore);
        push_random_samples(n);
        return n + 1;
    endfunction

    initial begin
        int useful;
        useful = 0;
        foreach (iq_sums[j]) iq_sums[j] = 0;
        build_coef_table();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle sample, zero sample count, restart while running.
        write_reg(REG_SAMPLE_COUNT, 0);
        write_reg(REG_IGNORE_SAMPLES, 0);
        push_item(OP_SAMPLE, '1, '0, '1);
        push_item(OP_START, '0, '0, '0);
        for (int i = 0; i < TABLE_LEN; i++) begin
            push_item(OP_SAMPLE, i[0] ? 12'hFFF : 12'h000, i[1] ? 12'hFFF : 12'h555,
                      i[2] ? 12'hAAA : 12'hFFF);
        end
        push_item(OP_START, '1, '1, '1);
        push_item(OP_SAMPLE, '1, '1, '1);
        push_item(OP_SAMPLE, '0, '1, '0);
        push_item(OP_START, '1, '1, '1);
        for (int i = 0; i < TABLE_LEN; i++) begin
            push_item(OP_SAMPLE, '1, '1, '1);
        end
        wait_idle();

        // Longest settling time the register allows; the run is restarted
        // long before the settling ends.
        write_reg(REG_IGNORE_SAMPLES, 65535);
        push_item(OP_START, rand_sample(), rand_sample(), rand_sample());
        push_random_samples(40);
        wait_idle();

        // Large sample count (2^20): a partial run that is restarted.
        write_reg(REG_SAMPLE_COUNT, 1048576);
        write_reg(REG_IGNORE_SAMPLES, 0);
        push_item(OP_START, rand_sample(), rand_sample(), rand_sample());
        push_random_samples(64);
        push_item(OP_START, rand_sample(), rand_sample(), rand_sample());
        push_random_samples(5);

        while (useful < 1250) begin
            wait_idle();
            write_reg(REG_SAMPLE_COUNT, ($urandom_range(0, 7) == 0)
                      ? $urandom_range(49, 200) : $urandom_range(0, 48));
            write_reg(REG_IGNORE_SAMPLES, ($urandom_range(0, 5) == 0)
                      ? $urandom_range(5, 40) : $urandom_range(0, 4));
            repeat ($urandom_range(2, 6)) begin
                case ($urandom_range(0, 9))
                    0: begin
                        // Noise of random kinds, including samples while idle.
                        repeat ($urandom_range(1, 5)) begin
                            push_item(1'($urandom_range(0, 1)), rand_sample(),
                                      rand_sample(), rand_sample());
                        end
                    end
                    1: begin
                        // A short run, broken off by the next start if it has not finished.
                        push_item(OP_START, rand_sample(), rand_sample(), rand_sample());
                        push_random_samples($urandom_range(1, cfg_ignore + 12));
                        useful += 1;
                    end
                    default: useful += push_measurement();
                endcase
            end
            // Samples arriving after a finished run are dropped.
            if ($urandom_range(0, 2) == 0) begin
                push_random_samples($urandom_range(1, 3));
            end
        end

        wait_idle();
        if (err_count == 0) begin
            $display("three_channel_iq_demodulator_top_tb OK");
        end else begin
            $display("three_channel_iq_demodulator_top_tb NOT OK");
        end
        $finish;
    end

endmodule
